// ----- rtl/bmf_pkg.sv -----
// ---------------------------------------------------------------------------
// bmf_pkg
// Shared constants, types and helper functions of the 3x3 box mean filter.
// ---------------------------------------------------------------------------
package bmf_pkg;

  // Line buffer geometry.
  localparam int unsigned LINE_SAMPLES = 16384;
  localparam int unsigned ADDR_W       = $clog2(LINE_SAMPLES);

  // Channel handling.
  localparam int unsigned MAX_CH   = 4;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned CNT_CH_W = 3;

  // Configuration register layout.
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNELS = 2'd2;
  localparam logic [CFG_W-1:0]     WIDTH_RST        = 13'd640;
  localparam logic [CFG_W-1:0]     HEIGHT_RST       = 13'd480;
  localparam logic [CNT_CH_W-1:0]  CHANNELS_RST     = 3'd1;
  localparam int unsigned          MIN_WIDTH        = 2;

  // Frame geometry.
  localparam int unsigned ROW_LIMIT = 4096;
  localparam int unsigned ROW_W     = 12;

  // Datapath widths.
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned HSUM_W   = 10;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned FACTOR_W = 13;
  localparam int unsigned PROD_W   = SUM_W + FACTOR_W;
  localparam int unsigned MEAN_SHIFT = 16;
  localparam logic [FACTOR_W-1:0] DIV9_FACTOR = 13'd7282;
  localparam logic [SUM_W-1:0]    DIV9_ROUND  = 12'd5;
  localparam logic [PIX_W-1:0]    MEAN_MAX    = 8'hFF;

  // Result queue.
  localparam int unsigned MAX_RES     = 4;
  localparam int unsigned RES_CNT_W   = 3;
  localparam int unsigned FIFO_DEPTH  = 16;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned LVL_W       = FIFO_AW + 1;
  localparam int unsigned READY_LIMIT = FIFO_DEPTH - MAX_RES;

  // Largest line width in pixels for a given channel count (minus one).
  function automatic logic [ADDR_W:0] width_limit(input logic [CH_W-1:0] ch_m1);
    logic [ADDR_W:0] lim;
    case (ch_m1)
      2'd0:    lim = (ADDR_W+1)'(LINE_SAMPLES / 1);
      2'd1:    lim = (ADDR_W+1)'(LINE_SAMPLES / 2);
      2'd2:    lim = (ADDR_W+1)'(LINE_SAMPLES / 3);
      default: lim = (ADDR_W+1)'(LINE_SAMPLES / 4);
    endcase
    return lim;
  endfunction

  // Request from the sample front end to the column stage.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;       // line buffer entry of the pixel left of the current one
    logic [HSUM_W-1:0] h_cur;      // horizontal 3-sum centered on the previous pixel
    logic [HSUM_W-1:0] h_edge;     // horizontal 3-sum centered on the last pixel
    logic [CH_W-1:0]   ch;         // channel of this item
    logic              first_row;
    logic              last_row;
    logic              last_px;
    logic              frame_end;
  } col_req_t;

  // One 3x3 sum waiting for the divide and the output port.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
    logic             frame_end;
  } res_t;

  // Status of the result queue toward the top level.
  typedef struct packed {
    logic             ready;
    logic [LVL_W-1:0] level;
  } out_stat_t;

endpackage

// ----- rtl/bmf_front.sv -----
// ---------------------------------------------------------------------------
// bmf_front
// Configuration registers, raster counters and the per-channel sample window.
// Builds the horizontal 3-sums and the line buffer address for each item.
// ---------------------------------------------------------------------------
module bmf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           accept_i,
  input  logic [bmf_pkg::PIX_W-1:0]      sample_i,
  output logic                           req_valid_o,
  output bmf_pkg::col_req_t              req_o
);

  logic [bmf_pkg::CFG_W-1:0]    width_q, width_d;
  logic [bmf_pkg::CFG_W-1:0]    height_q, height_d;
  logic [bmf_pkg::CNT_CH_W-1:0] chan_q, chan_d;
  logic                         cfg_hit;

  logic [bmf_pkg::CNT_CH_W-1:0] ch_eff;
  logic [bmf_pkg::CH_W-1:0]     ch_m1;
  logic [bmf_pkg::ADDR_W:0]     lim;
  logic [bmf_pkg::CFG_W-1:0]    w_eff, w_m1;
  logic [bmf_pkg::CFG_W-1:0]    h_eff;
  logic [bmf_pkg::ROW_W-1:0]    h_m1;

  logic [bmf_pkg::ADDR_W-1:0]   col_q, col_d;
  logic [bmf_pkg::CFG_W-1:0]    x_q, x_d;
  logic [bmf_pkg::CH_W-1:0]     c_q, c_d;
  logic [bmf_pkg::ROW_W-1:0]    row_q, row_d;

  logic [bmf_pkg::PIX_W-1:0]    left_q [bmf_pkg::MAX_CH];
  logic [bmf_pkg::PIX_W-1:0]    mid_q  [bmf_pkg::MAX_CH];
  logic [bmf_pkg::PIX_W-1:0]    left, mid;

  logic x_first, last_px, last_ch, first_row, last_row;

  // Register writes; any valid index restarts the frame.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    chan_d   = chan_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bmf_pkg::CFG_IDX_WIDTH: begin
          width_d = cfg_data_i;
          cfg_hit = 1'b1;
        end
        bmf_pkg::CFG_IDX_HEIGHT: begin
          height_d = cfg_data_i;
          cfg_hit  = 1'b1;
        end
        bmf_pkg::CFG_IDX_CHANNELS: begin
          chan_d  = cfg_data_i[bmf_pkg::CNT_CH_W-1:0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // Clamp the registers to the supported geometry.
  always_comb begin
    if (chan_q == '0) begin
      ch_eff = bmf_pkg::CNT_CH_W'(1);
    end else if (chan_q > bmf_pkg::CNT_CH_W'(bmf_pkg::MAX_CH)) begin
      ch_eff = bmf_pkg::CNT_CH_W'(bmf_pkg::MAX_CH);
    end else begin
      ch_eff = chan_q;
    end
    ch_m1 = bmf_pkg::CH_W'(ch_eff - bmf_pkg::CNT_CH_W'(1));
    lim   = bmf_pkg::width_limit(ch_m1);

    if (width_q < bmf_pkg::CFG_W'(bmf_pkg::MIN_WIDTH)) begin
      w_eff = bmf_pkg::CFG_W'(bmf_pkg::MIN_WIDTH);
    end else if ((bmf_pkg::ADDR_W+1)'(width_q) > lim) begin
      w_eff = bmf_pkg::CFG_W'(lim);
    end else begin
      w_eff = width_q;
    end
    w_m1 = w_eff - bmf_pkg::CFG_W'(1);

    if (height_q == '0) begin
      h_eff = bmf_pkg::CFG_W'(1);
    end else if (height_q > bmf_pkg::CFG_W'(bmf_pkg::ROW_LIMIT)) begin
      h_eff = bmf_pkg::CFG_W'(bmf_pkg::ROW_LIMIT);
    end else begin
      h_eff = height_q;
    end
    h_m1 = bmf_pkg::ROW_W'(h_eff - bmf_pkg::CFG_W'(1));
  end

  // Position flags of the current item.
  assign x_first   = (x_q == '0);
  assign last_px   = (x_q == w_m1);
  assign last_ch   = (c_q == ch_m1);
  assign first_row = (row_q == '0);
  assign last_row  = (row_q == h_m1);

  assign left = left_q[c_q];
  assign mid  = mid_q[c_q];

  // Raster counters: channel, pixel, sample index and row.
  always_comb begin
    col_d = col_q;
    x_d   = x_q;
    c_d   = c_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      x_d   = '0;
      c_d   = '0;
      row_d = '0;
    end else if (accept_i) begin
      if (last_ch && last_px) begin
        col_d = '0;
        x_d   = '0;
        c_d   = '0;
        row_d = last_row ? '0 : row_q + bmf_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + bmf_pkg::ADDR_W'(1);
        if (last_ch) begin
          c_d = '0;
          x_d = x_q + bmf_pkg::CFG_W'(1);
        end else begin
          c_d = c_q + bmf_pkg::CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bmf_pkg::WIDTH_RST;
      height_q <= bmf_pkg::HEIGHT_RST;
      chan_q   <= bmf_pkg::CHANNELS_RST;
      col_q    <= '0;
      x_q      <= '0;
      c_q      <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      chan_q   <= chan_d;
      col_q    <= col_d;
      x_q      <= x_d;
      c_q      <= c_d;
      row_q    <= row_d;
    end
  end

  // Sample window: the two previous samples of each channel.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      left_q[c_q] <= x_first ? sample_i : mid;
      mid_q[c_q]  <= sample_i;
    end
  end

  // Column request; the first pixel of a line only primes the window.
  always_comb begin
    req_valid_o      = accept_i && !x_first;
    req_o.addr       = col_q - bmf_pkg::ADDR_W'(ch_eff);
    req_o.h_cur      = bmf_pkg::HSUM_W'(left) + bmf_pkg::HSUM_W'(mid)
                     + bmf_pkg::HSUM_W'(sample_i);
    req_o.h_edge     = bmf_pkg::HSUM_W'(mid) + (bmf_pkg::HSUM_W'(sample_i) << 1);
    req_o.ch         = c_q;
    req_o.first_row  = first_row;
    req_o.last_row   = last_row;
    req_o.last_px    = last_px;
    req_o.frame_end  = last_row && last_px && last_ch;
  end

endmodule

// ----- rtl/bmf_column.sv -----
// ---------------------------------------------------------------------------
// bmf_column
// Line buffer of row sums with read-modify-write per item. Adds three rows
// and hands up to four 3x3 sums to the result queue in output order.
// ---------------------------------------------------------------------------
module bmf_column (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  input  bmf_pkg::col_req_t                    req_i,
  output logic                                 s1_valid_o,
  output logic [bmf_pkg::MAX_RES-1:0]          res_valid_o,
  output bmf_pkg::res_t [bmf_pkg::MAX_RES-1:0] res_o
);

  localparam int unsigned WORD_W = 2 * bmf_pkg::HSUM_W;

  // Each entry holds the row sums of the two rows above: {older, newer}.
  logic [WORD_W-1:0]          line_mem [bmf_pkg::LINE_SAMPLES];
  logic [WORD_W-1:0]          rd_q;
  logic                       s1_valid_q;
  bmf_pkg::col_req_t          s1_q;

  // The last pixel of a line keeps its row sums per channel in flip-flops.
  logic [bmf_pkg::HSUM_W-1:0] edge_a_q [bmf_pkg::MAX_CH];
  logic [bmf_pkg::HSUM_W-1:0] edge_b_q [bmf_pkg::MAX_CH];

  logic [bmf_pkg::HSUM_W-1:0] a_cur, b_cur, a_edge, b_edge;
  logic [bmf_pkg::SUM_W-1:0]  sums [bmf_pkg::MAX_RES];
  logic [bmf_pkg::RES_CNT_W-1:0] last_idx;

  // Stage register; the column stage never stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      s1_q <= req_i;
    end
  end

  // Synchronous line buffer: read at acceptance, written back in the following cycle.
  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      rd_q <= line_mem[req_i.addr];
    end
    if (s1_valid_q) begin
      line_mem[s1_q.addr] <= {b_cur, s1_q.h_cur};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_q.last_px) begin
      edge_a_q[s1_q.ch] <= b_edge;
      edge_b_q[s1_q.ch] <= s1_q.h_edge;
    end
  end

  // On the first row the rows above replicate the current one.
  always_comb begin
    a_cur  = s1_q.first_row ? s1_q.h_cur  : rd_q[WORD_W-1:bmf_pkg::HSUM_W];
    b_cur  = s1_q.first_row ? s1_q.h_cur  : rd_q[bmf_pkg::HSUM_W-1:0];
    a_edge = s1_q.first_row ? s1_q.h_edge : edge_a_q[s1_q.ch];
    b_edge = s1_q.first_row ? s1_q.h_edge : edge_b_q[s1_q.ch];
  end

  // Slots in output order: row above (pixel, edge), last row (pixel, edge).
  always_comb begin
    sums[0] = bmf_pkg::SUM_W'(a_cur) + bmf_pkg::SUM_W'(b_cur)
            + bmf_pkg::SUM_W'(s1_q.h_cur);
    sums[1] = bmf_pkg::SUM_W'(a_edge) + bmf_pkg::SUM_W'(b_edge)
            + bmf_pkg::SUM_W'(s1_q.h_edge);
    sums[2] = bmf_pkg::SUM_W'(b_cur) + (bmf_pkg::SUM_W'(s1_q.h_cur) << 1);
    sums[3] = bmf_pkg::SUM_W'(b_edge) + (bmf_pkg::SUM_W'(s1_q.h_edge) << 1);

    res_valid_o[0] = s1_valid_q && !s1_q.first_row;
    res_valid_o[1] = s1_valid_q && !s1_q.first_row && s1_q.last_px;
    res_valid_o[2] = s1_valid_q && s1_q.last_row;
    res_valid_o[3] = s1_valid_q && s1_q.last_row && s1_q.last_px;

    last_idx = '0;
    for (int i = 0; i < bmf_pkg::MAX_RES; i++) begin
      if (res_valid_o[i]) begin
        last_idx = bmf_pkg::RES_CNT_W'(i);
      end
    end

    for (int i = 0; i < bmf_pkg::MAX_RES; i++) begin
      res_o[i].sum       = sums[i];
      res_o[i].last      = (last_idx == bmf_pkg::RES_CNT_W'(i));
      res_o[i].frame_end = (last_idx == bmf_pkg::RES_CNT_W'(i)) && s1_q.frame_end;
    end
  end

  assign s1_valid_o = s1_valid_q;

endmodule

// ----- rtl/bmf_out.sv -----
// ---------------------------------------------------------------------------
// bmf_out
// Result queue that takes up to four sums per cycle, the divide by nine by
// reciprocal multiply, and the registered output stage.
// ---------------------------------------------------------------------------
module bmf_out (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s1_valid_i,
  input  logic [bmf_pkg::MAX_RES-1:0]          res_valid_i,
  input  bmf_pkg::res_t [bmf_pkg::MAX_RES-1:0] res_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [bmf_pkg::PIX_W-1:0]            mean_o,
  output logic                                 last_o,
  output logic                                 frame_end_o,
  output bmf_pkg::out_stat_t                   stat_o
);

  bmf_pkg::res_t                  fifo_q [bmf_pkg::FIFO_DEPTH];
  logic [bmf_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [bmf_pkg::LVL_W-1:0]      level_q;
  logic [bmf_pkg::RES_CNT_W-1:0]  off [bmf_pkg::MAX_RES];
  logic [bmf_pkg::RES_CNT_W-1:0]  push_n;
  logic                           pop;
  bmf_pkg::res_t                  head;

  logic                           out_valid_q;
  logic [bmf_pkg::PIX_W-1:0]      mean_q;
  logic                           last_q, frame_end_q;
  logic [bmf_pkg::PROD_W-1:0]     prod;
  logic [bmf_pkg::PROD_W-bmf_pkg::MEAN_SHIFT-1:0] scaled;
  logic [bmf_pkg::PIX_W-1:0]      mean_d;

  // Pack the valid slots next to each other.
  always_comb begin
    off[0] = '0;
    for (int i = 1; i < bmf_pkg::MAX_RES; i++) begin
      off[i] = off[i-1] + bmf_pkg::RES_CNT_W'(res_valid_i[i-1]);
    end
    push_n = off[bmf_pkg::MAX_RES-1]
           + bmf_pkg::RES_CNT_W'(res_valid_i[bmf_pkg::MAX_RES-1]);
  end

  assign pop  = (level_q != '0) && (!out_valid_q || out_ready_i);
  assign head = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < bmf_pkg::MAX_RES; i++) begin
      if (res_valid_i[i]) begin
        fifo_q[wr_ptr_q + bmf_pkg::FIFO_AW'(off[i])] <= res_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + bmf_pkg::FIFO_AW'(push_n);
      rd_ptr_q <= rd_ptr_q + bmf_pkg::FIFO_AW'(pop);
      level_q  <= level_q + bmf_pkg::LVL_W'(push_n) - bmf_pkg::LVL_W'(pop);
    end
  end

  // Mean: ((sum + 5) * 7282) >> 16, saturated to one byte.
  always_comb begin
    prod   = bmf_pkg::PROD_W'(head.sum + bmf_pkg::DIV9_ROUND)
           * bmf_pkg::PROD_W'(bmf_pkg::DIV9_FACTOR);
    scaled = prod[bmf_pkg::PROD_W-1:bmf_pkg::MEAN_SHIFT];
    if (scaled > (bmf_pkg::PROD_W-bmf_pkg::MEAN_SHIFT)'(bmf_pkg::MEAN_MAX)) begin
      mean_d = bmf_pkg::MEAN_MAX;
    end else begin
      mean_d = scaled[bmf_pkg::PIX_W-1:0];
    end
  end

  // Output register decouples the port from the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      mean_q      <= mean_d;
      last_q      <= head.last;
      frame_end_q <= head.frame_end;
    end
  end

  // Room for one item in the column stage and one more being accepted.
  always_comb begin
    stat_o.level = level_q;
    stat_o.ready = (level_q + (s1_valid_i ? bmf_pkg::LVL_W'(bmf_pkg::MAX_RES) : '0))
                 <= bmf_pkg::LVL_W'(bmf_pkg::READY_LIMIT);
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign last_o      = last_q;
  assign frame_end_o = frame_end_q;

endmodule

// ----- rtl/box_mean_filter_3x3_unit.sv -----
// ---------------------------------------------------------------------------
// box_mean_filter_3x3_unit
// 3x3 box mean over an interleaved 8-bit image in raster order, edges
// replicated, one channel sample per item.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid/tready          tdata[7:0] sample
//  m_axis    out        tvalid/tready          tdata[7:0] mean_value, tlast
//                                              last_of_run, tuser end_of_frame
//  cfg       in         cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
//  One item is accepted per cycle while the queue has room, and each item
//  causes up to four results; a 16-entry result queue absorbs the burst
//  at line and frame ends. With the queue empty, the first result of an item
//  passes the column stage register, the result queue and the output
//  register before it is valid at the output. The input stalls while the queue
//  level, plus four for a column push still pending, exceeds twelve.
//  Row sums live in a 16384 x 20 bit line buffer read at acceptance and
//  written back the next cycle; reset needs no clearing pass.
//  Reset loads width 640, height 480, one channel and restarts the frame.
// ---------------------------------------------------------------------------
module box_mean_filter_3x3_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmf_pkg::CFG_W-1:0]      cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] sample
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] mean_value
  output logic                           m_axis_tlast,   // last_of_run
  output logic                           m_axis_tuser    // [0] end_of_frame
);

  logic                                 accept;
  logic                                 req_valid;
  bmf_pkg::col_req_t                    req;
  logic                                 s1_valid;
  logic [bmf_pkg::MAX_RES-1:0]          res_valid;
  bmf_pkg::res_t [bmf_pkg::MAX_RES-1:0] res;
  bmf_pkg::out_stat_t                   stat;

  assign s_axis_tready = stat.ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Counters, window and horizontal sums.
  bmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .sample_i    (s_axis_tdata),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // Line buffer and vertical sums.
  bmf_column u_column (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .s1_valid_o  (s1_valid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result queue, divide and output register.
  bmf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .mean_o      (m_axis_tdata),
    .last_o      (m_axis_tlast),
    .frame_end_o (m_axis_tuser),
    .stat_o      (stat)
  );

  // The column stage never pushes more sums than the queue can still hold.
  a_queue_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid |-> (stat.level <= bmf_pkg::LVL_W'(bmf_pkg::READY_LIMIT)))
    else $error("result queue overflow");

  // The end of a frame is always the last result of its item.
  a_eof_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("end_of_frame without last_of_run");

  // A column request only comes with an accepted item.
  a_no_req_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> !req_valid)
    else $error("column request without an accepted item");

endmodule

// ----- sim/box_mean_filter_3x3_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_mean_filter_3x3_unit_test
// Self-checking bench for the 3x3 box mean filter. Samples stream in through
// a randomly throttled driver. A behavioral line-buffer predictor computes
// the expected means, tlast and tuser, and the monitor compares every output
// item in order. Frame geometry is reprogrammed between phases, from the
// clamped extremes down to small random frames, some of them cut short.
// ---------------------------------------------------------------------------
module box_mean_filter_3x3_unit_test;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ITEMS_MIN    = 150;
  localparam int unsigned ITEMS_MAX    = 165;
  localparam logic [bmf_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [bmf_pkg::PIX_W-1:0] mean_value;
    logic                      last_of_run;
    logic                      end_of_frame;
  } mean_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bmf_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;
  logic                          m_axis_tuser;

  box_mean_filter_3x3_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] sample
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [7:0] mean_value
    .m_axis_tlast (m_axis_tlast),   // last_of_run
    .m_axis_tuser (m_axis_tuser)    // [0] end_of_frame
  );

  // Stimulus and scoreboard storage.
  logic [7:0]   sample_queue[$];
  mean_result_t expected_means[$];
  int unsigned  samples_queued = 0;
  int unsigned  samples_taken = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  bit           in_taken = 1'b0;

  // Predictor state: row sums of the two previous lines and the last two
  // samples of each channel.
  logic [bmf_pkg::HSUM_W-1:0]   hsum_older[bmf_pkg::LINE_SAMPLES];
  logic [bmf_pkg::HSUM_W-1:0]   hsum_newer[bmf_pkg::LINE_SAMPLES];
  logic [bmf_pkg::PIX_W-1:0]    recent_samples[2*bmf_pkg::MAX_CH] = '{default: '0};
  int unsigned                  col_pos = 0;
  int unsigned                  row_pos = 0;
  logic [bmf_pkg::CFG_W-1:0]    reg_width = 13'd640;
  logic [bmf_pkg::CFG_W-1:0]    reg_height = 13'd480;
  logic [bmf_pkg::CNT_CH_W-1:0] reg_channels = 3'd1;

  // Clock and a single reset pulse.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Register write as the predictor sees it; any known index restarts the frame.
  function automatic void apply_reg(input logic [bmf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bmf_pkg::CFG_W-1:0] val);
    case (idx)
      bmf_pkg::CFG_IDX_WIDTH:    reg_width = val;
      bmf_pkg::CFG_IDX_HEIGHT:   reg_height = val;
      bmf_pkg::CFG_IDX_CHANNELS: reg_channels = val[bmf_pkg::CNT_CH_W-1:0];
      default:                   return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic logic [bmf_pkg::PIX_W-1:0] box_mean(input int unsigned sum);
    int unsigned v;
    v = ((sum + bmf_pkg::DIV9_ROUND) * bmf_pkg::DIV9_FACTOR) >> bmf_pkg::MEAN_SHIFT;
    return (v > bmf_pkg::MEAN_MAX) ? bmf_pkg::MEAN_MAX : bmf_pkg::PIX_W'(v);
  endfunction

  // Merge one finished horizontal sum into the line buffers; gives the 3x3
  // sum centered on the row above and, on the last row, on this row.
  function automatic void fold_column(input int unsigned idx, input int unsigned h,
                                      input int unsigned r, input int unsigned hgt,
                                      output bit has_up, output int unsigned up_sum,
                                      output bit has_cur, output int unsigned cur_sum);
    int unsigned a, b;
    if (idx >= bmf_pkg::LINE_SAMPLES) idx = 0;
    if (r == 0) begin
      hsum_older[idx] = bmf_pkg::HSUM_W'(h);
      hsum_newer[idx] = bmf_pkg::HSUM_W'(h);
    end
    a = hsum_older[idx];
    b = hsum_newer[idx];
    has_up  = (r >= 1);
    up_sum  = a + b + h;
    has_cur = (r == hgt - 1);
    cur_sum = b + 2 * h;
    if (r >= 1) begin
      hsum_older[idx] = bmf_pkg::HSUM_W'(b);
      hsum_newer[idx] = bmf_pkg::HSUM_W'(h);
    end
  endfunction

  // Advance the predictor by one sample and queue the means it completes.
  function automatic void predict_box_means(input logic [bmf_pkg::PIX_W-1:0] s);
    int unsigned ch, w, hgt, len, col, r, x, c, left, mid, n;
    int unsigned us_i, cs_i, us_j, cs_j;
    int unsigned sums[4];
    bit up_i, cur_i, up_j, cur_j, last_px;
    mean_result_t res;
    ch = reg_channels;
    if (ch < 1) ch = 1;
    if (ch > bmf_pkg::MAX_CH) ch = bmf_pkg::MAX_CH;
    w = reg_width;
    if (w < bmf_pkg::MIN_WIDTH) w = bmf_pkg::MIN_WIDTH;
    if (w > bmf_pkg::LINE_SAMPLES / ch) w = bmf_pkg::LINE_SAMPLES / ch;
    hgt = reg_height;
    if (hgt < 1) hgt = 1;
    if (hgt > bmf_pkg::ROW_LIMIT) hgt = bmf_pkg::ROW_LIMIT;
    len = w * ch;
    col = (col_pos >= len) ? 0 : col_pos;
    r = (row_pos >= hgt) ? 0 : row_pos;
    x = col / ch;
    c = col % ch;
    n = 0;
    if (x == 0) begin
      recent_samples[2*c]   = s;
      recent_samples[2*c+1] = s;
    end else begin
      left = recent_samples[2*c];
      mid  = recent_samples[2*c+1];
      last_px = (x == w - 1);
      up_j = 1'b0;
      cur_j = 1'b0;
      us_j = 0;
      cs_j = 0;
      recent_samples[2*c]   = bmf_pkg::PIX_W'(mid);
      recent_samples[2*c+1] = s;
      fold_column((x - 1) * ch + c, left + mid + s, r, hgt, up_i, us_i, cur_i, cs_i);
      // The last pixel also closes its own column, replicated on the right.
      if (last_px)
        fold_column(x * ch + c, mid + 2 * s, r, hgt, up_j, us_j, cur_j, cs_j);
      if (up_i) begin
        sums[n] = us_i;
        n++;
      end
      if (up_j) begin
        sums[n] = us_j;
        n++;
      end
      if (cur_i) begin
        sums[n] = cs_i;
        n++;
      end
      if (cur_j) begin
        sums[n] = cs_j;
        n++;
      end
      for (int k = 0; k < n; k++) begin
        res.mean_value   = box_mean(sums[k]);
        res.last_of_run  = (k == n - 1);
        res.end_of_frame = (k == n - 1) && (r == hgt - 1) && last_px && (c == ch - 1);
        expected_means.push_back(res);
      end
    end
    col++;
    if (col >= len) begin
      col = 0;
      r++;
      if (r >= hgt) r = 0;
    end
    col_pos = col;
    row_pos = r;
  endfunction

  // Driver: inputs change on the falling edge; a held item stays until taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted sample, check each accepted result.
  always @(posedge clk_i) begin
    mean_result_t want;
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        predict_box_means(s_axis_tdata);
        samples_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("unexpected result, mean %0d", m_axis_tdata));
        end else begin
          want = expected_means.pop_front();
          if (m_axis_tdata !== want.mean_value)
            report_mismatch($sformatf("mean_value %0d, expected %0d",
                                      m_axis_tdata, want.mean_value));
          if (m_axis_tlast !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      m_axis_tlast, want.last_of_run));
          if (m_axis_tuser !== want.end_of_frame)
            report_mismatch($sformatf("end_of_frame %b, expected %b",
                                      m_axis_tuser, want.end_of_frame));
        end
      end
    end
  end

  // Wait until every queued sample is taken and every result has left,
  // then give the pipeline time to finish items that produce no result.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (samples_taken != samples_queued || expected_means.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [bmf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bmf_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // New frame geometry once idle; the throttling profile follows progress.
  task automatic configure(input logic [bmf_pkg::CFG_W-1:0] w,
                           input logic [bmf_pkg::CFG_W-1:0] h,
                           input logic [bmf_pkg::CFG_W-1:0] chv);
    wait_drained();
    write_reg(bmf_pkg::CFG_IDX_WIDTH, w);
    write_reg(bmf_pkg::CFG_IDX_HEIGHT, h);
    write_reg(bmf_pkg::CFG_IDX_CHANNELS, chv);
    if (samples_queued < 55) begin
      send_idle_pct = 21;
      recv_idle_pct = 51;
    end else if (samples_queued < 110) begin
      send_idle_pct = 51;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic queue_sample(input logic [7:0] s);
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    int unsigned w, h, chv, n;
    logic [7:0] row_top[6];
    logic [7:0] row_bottom[6];
    row_top    = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F};
    row_bottom = '{8'hFF, 8'hFF, 8'h01, 8'hFE, 8'h55, 8'hAA};
    @(posedge rst_ni);

    // All registers at zero clamp to a 2x1 single-channel frame, so the
    // single row is replicated above and below. Saturated and empty frames.
    configure(13'd0, 13'd0, 13'd0);
    queue_sample(8'hFF);
    queue_sample(8'hFF);
    queue_sample(8'h00);
    queue_sample(8'h00);

    // Two-channel 3x2 frame; a write to the unused index between the rows
    // must not restart the frame.
    configure(13'd3, 13'd2, 13'd2);
    foreach (row_top[i]) queue_sample(row_top[i]);
    wait_drained();
    write_reg(CFG_IDX_UNUSED, 13'h1FFF);
    foreach (row_bottom[i]) queue_sample(row_bottom[i]);

    // Top of every register: channels clamp to four, width to the line
    // buffer size over four channels. Only the start of the single long line is sent.
    configure(13'h1FFF, 13'd1, 13'd7);
    repeat (40) queue_sample(bmf_pkg::PIX_W'($urandom_range(255)));

    // Tallest frame at the narrowest width, cut short after some rows.
    configure(13'd2, 13'h1FFF, 13'd1);
    repeat (30) queue_sample(bmf_pkg::PIX_W'($urandom_range(255)));

    // Mostly whole small frames with random content; some are cut short,
    // and some are single long lines of random width.
    while (samples_queued < ITEMS_MIN) begin
      if ($urandom_range(5) == 0) begin
        w = $urandom_range(2, 13'h1FFF);
        h = 1;
        chv = $urandom_range(0, 7);
        n = $urandom_range(4, 30);
      end else begin
        w = $urandom_range(2, 5);
        h = $urandom_range(1, 3);
        chv = $urandom_range(1, 4);
        n = w * h * chv * $urandom_range(1, 2);
        if ($urandom_range(4) == 0) n = $urandom_range(1, n - 1);
      end
      if (samples_queued + n > ITEMS_MAX) n = ITEMS_MAX - samples_queued;
      configure(bmf_pkg::CFG_W'(w), bmf_pkg::CFG_W'(h), bmf_pkg::CFG_W'(chv));
      repeat (n) queue_sample(bmf_pkg::PIX_W'($urandom_range(255)));
    end

    // Let everything drain; a result still missing after the limit fails.
    do @(negedge clk_i);
    while (samples_taken != samples_queued);
    n = 0;
    while (expected_means.size() != 0 && n < 4000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_means.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_means.size()));

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
